// ===== src/bprq_pkg.sv =====
`timescale 1ns / 1ps

package bprq_pkg;

  // Opcodes
  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // Bitmap scan: groups of eight levels, two steps per search
  localparam int GROUP_BITS = 8;
  localparam int GROUP_IW   = 3;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       opcode;
    logic [5:0] task_id;
    logic [5:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] out_task;
    logic [5:0] out_priority;
    logic       any_ready;
  } out_item_t;

  // Classified command as queued for the back end
  typedef struct packed {
    logic       is_get;
    logic       bad_task;
    logic [5:0] task_id;
    logic [5:0] level;
  } work_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PUT_WR,
    B_GET_RD,
    B_GET_LINK,
    B_GET_WR
  } back_state_t;

endpackage

// ===== src/bprq_front.sv =====
`timescale 1ns / 1ps

module bprq_front import bprq_pkg::*; #(
  parameter int PRIORITY_LEVELS = 64,
  parameter int TASK_SLOTS      = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_data,
  output logic     busy,
  output logic     item_valid,
  output work_t    item,
  input  logic     item_pop
);

  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  work_t            slot_r [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   count_r;
  work_t            cls;
  logic             push;

  // Classify: range check on the slot, saturate the level
  always_comb begin
    cls.is_get   = (in_data.opcode == OP_GET);
    cls.bad_task = (int'(in_data.task_id) >= TASK_SLOTS);
    cls.task_id  = in_data.task_id;
    cls.level    = (int'(in_data.priority_req) >= PRIORITY_LEVELS) ?
                   6'(PRIORITY_LEVELS - 1) : in_data.priority_req;
  end

  assign busy       = (count_r == QCW'(QUEUE_DEPTH));
  assign push       = start && !busy;
  assign item_valid = (count_r != '0);
  assign item       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (item_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, item_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== src/bprq_back.sv =====
`timescale 1ns / 1ps

module bprq_back import bprq_pkg::*; #(
  parameter int PRIORITY_LEVELS = 64,
  parameter int TASK_SLOTS      = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  work_t     item,
  output logic      item_pop,
  output logic      res_valid,
  output out_item_t res
);

  localparam int LW   = $clog2(PRIORITY_LEVELS);
  localparam int SW   = $clog2(TASK_SLOTS);
  localparam int NG   = (PRIORITY_LEVELS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
  localparam int PADW = NG * GROUP_BITS;

  back_state_t                state_r, state_nxt;
  work_t                      work_r;
  logic [PRIORITY_LEVELS-1:0] bitmap_r, bitmap_nxt;
  logic [TASK_SLOTS-1:0]      queued_r, queued_nxt;

  logic [5:0] head_mem [PRIORITY_LEVELS];
  logic [5:0] tail_mem [PRIORITY_LEVELS];
  logic [5:0] link_mem [TASK_SLOTS];
  logic [5:0] head_rd_r, tail_rd_r, link_rd_r;

  logic [PADW-1:0]       bm_pad;
  logic [GW-1:0]         grp_r, grp_c;
  logic [GROUP_BITS-1:0] grp_bits_r, grp_bits_c;
  logic [GROUP_IW-1:0]   bit_c;
  logic                  empty_r;
  logic [LW-1:0]         lvl_r, lvl_c, rd_lvl, put_lvl, head_wa;
  logic [SW-1:0]         put_idx, get_idx, link_wa;
  logic                  rd_en, head_we, tail_we, link_we;
  logic [5:0]            head_wd;
  logic                  put_bit, reject, last;
  logic                  emit;
  out_item_t             res_c;
  logic                  res_valid_r;
  out_item_t             res_r;

  // First step of the lowest-set-bit search: lowest nonzero group
  always_comb begin
    bm_pad     = PADW'(bitmap_r);
    grp_c      = '0;
    grp_bits_c = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (|bm_pad[g*GROUP_BITS +: GROUP_BITS]) begin
        grp_c      = GW'(g);
        grp_bits_c = bm_pad[g*GROUP_BITS +: GROUP_BITS];
      end
    end
  end

  // Second step: lowest bit inside the registered group
  always_comb begin
    bit_c = '0;
    for (int b = GROUP_BITS - 1; b >= 0; b--) begin
      if (grp_bits_r[b]) begin
        bit_c = GROUP_IW'(b);
      end
    end
    lvl_c = LW'({grp_r, bit_c});
  end

  assign put_lvl = LW'(work_r.level);
  assign put_idx = SW'(work_r.task_id);
  assign get_idx = SW'(head_rd_r);
  assign put_bit = bitmap_r[put_lvl];
  assign reject  = work_r.bad_task || queued_r[put_idx];
  assign last    = (head_rd_r == tail_rd_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (item_valid) begin
          state_nxt = item.is_get ? B_GET_RD : B_PUT_WR;
        end
      end
      B_PUT_WR:   state_nxt = B_IDLE;
      B_GET_RD:   state_nxt = B_GET_LINK;
      B_GET_LINK: state_nxt = B_GET_WR;
      B_GET_WR:   state_nxt = B_IDLE;
      default:    state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    item_pop   = 1'b0;
    rd_en      = 1'b0;
    rd_lvl     = lvl_c;
    head_we    = 1'b0;
    tail_we    = 1'b0;
    link_we    = 1'b0;
    head_wa    = put_lvl;
    head_wd    = work_r.task_id;
    link_wa    = SW'(tail_rd_r);
    bitmap_nxt = bitmap_r;
    queued_nxt = queued_r;
    emit       = 1'b0;
    res_c      = '0;
    res_c.status = ST_OK;
    unique case (state_r)
      B_IDLE: begin
        item_pop = item_valid;
        rd_en    = 1'b1;
        rd_lvl   = LW'(item.level);
      end
      B_PUT_WR: begin
        emit = 1'b1;
        if (reject) begin
          res_c.status = ST_REJECT;
        end else begin
          tail_we              = 1'b1;
          head_we              = !put_bit;
          link_we              = put_bit;
          queued_nxt[put_idx]  = 1'b1;
          bitmap_nxt[put_lvl]  = 1'b1;
        end
      end
      B_GET_RD: begin
        rd_en = 1'b1;
      end
      B_GET_LINK: begin
      end
      B_GET_WR: begin
        emit = 1'b1;
        if (empty_r) begin
          res_c.status = ST_EMPTY;
        end else begin
          res_c.out_task      = head_rd_r;
          res_c.out_priority  = 6'(lvl_r);
          queued_nxt[get_idx] = 1'b0;
          if (last) begin
            bitmap_nxt[lvl_r] = 1'b0;
          end else begin
            head_we = 1'b1;
            head_wa = lvl_r;
            head_wd = link_rd_r;
          end
        end
      end
      default: begin
      end
    endcase
    res_c.any_ready = |bitmap_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      bitmap_r    <= '0;
      queued_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bitmap_r    <= bitmap_nxt;
      queued_r    <= queued_nxt;
      res_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      work_r     <= item;
      grp_r      <= grp_c;
      grp_bits_r <= grp_bits_c;
      empty_r    <= (bitmap_r == '0);
    end
    if (state_r == B_GET_RD) begin
      lvl_r <= lvl_c;
    end
    if (emit) begin
      res_r <= res_c;
    end
  end

  // Head, tail and link stores
  always_ff @(posedge clk) begin
    if (rd_en) begin
      head_rd_r <= head_mem[rd_lvl];
      tail_rd_r <= tail_mem[rd_lvl];
    end
    link_rd_r <= link_mem[get_idx];
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[put_lvl] <= work_r.task_id;
    end
    if (link_we) begin
      link_mem[link_wa] <= work_r.task_id;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== src/bitmap_priority_ready_queue.sv =====
`timescale 1ns / 1ps
// The back end takes one command at a time: a put in idle and write-back states, a get
//   through the two-step bitmap scan, head/tail read, link read and write-back.
// A 2-deep command queue lets start be taken while the back end works.
// Reset (rst_n low, synchronous) empties every level; results cannot be stalled.

module bitmap_priority_ready_queue import bprq_pkg::*; #(
  parameter int PRIORITY_LEVELS = 64,
  parameter int TASK_SLOTS      = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data
);

  // Front/back link: classified commands waiting for the back end
  logic  item_valid;
  logic  item_pop;
  work_t item;

  // Front: classify each transfer (slot range check, level saturation)
  // and hold it in the command queue. busy means the queue is full.
  bprq_front #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .TASK_SLOTS      (TASK_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .busy       (busy),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  // Back: occupancy bitmap, per-level linked-list FIFOs, result register.
  bprq_back #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .TASK_SLOTS      (TASK_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_valid  (out_valid),
    .res        (out_data)
  );

`ifndef ASSERT_OFF
  // Back end always returns to idle after a result: no back-to-back strobes
  a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on consecutive cycles");

  // An empty get leaves nothing queued
  a_empty_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_EMPTY) |-> !out_data.any_ready)
    else $error("empty get reports ready tasks");

  // Failed commands return no task
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |->
      (out_data.out_task == 6'd0 && out_data.out_priority == 6'd0))
    else $error("failed command returned a task");

  // An ok put always leaves something queued, so an ok result that drains
  // the queue is a get, strobed after the read, link and write-back states that follow its pop
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_OK && out_data.out_task == 6'd0 &&
     out_data.out_priority == 6'd0 && !out_data.any_ready) |->
      $past(item_pop, 4))
    else $error("draining ok result not timed as a get");
`endif

endmodule
